// ----- hw/rtl/wch_pkg.sv -----
// ----------------------------------------------------------------------------
// wch_pkg
// Shared constants and types of the weighted color histogram accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package wch_pkg;

  // store size and row width
  localparam int HIST_BINS = 4096;
  localparam int ROW_WIDTH = 4096;

  // derived widths
  localparam int ADDR_W   = $clog2(HIST_BINS);
  localparam int FLAT_W   = 28;   // x + y*bx + z*bx*by, 9 + 18 + 27 bit terms
  localparam int WEIGHT_W = 47;   // 12-bit column * 3-bit factor * 32-bit gain
  localparam int VALUE_W  = 48;
  localparam int INDEX_W  = 12;
  localparam int COLCMP_W = 17;   // wide enough to hold ROW_WIDTH

  // request opcodes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // histogram dimensionality codes
  localparam logic [1:0] DIM_TWO   = 2'd2;
  localparam logic [1:0] DIM_THREE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_HIST_CH = 3'd0;
  localparam logic [2:0] CFG_BINS_X  = 3'd1;
  localparam logic [2:0] CFG_BINS_Y  = 3'd2;
  localparam logic [2:0] CFG_BINS_Z  = 3'd3;
  localparam logic [2:0] CFG_SRC_CH  = 3'd4;
  localparam logic [2:0] CFG_GAIN    = 3'd5;

  typedef struct packed {
    logic [1:0]  hist_ch;
    logic [8:0]  bins_x;
    logic [8:0]  bins_y;
    logic [8:0]  bins_z;
    logic [2:0]  src_ch;
    logic [31:0] gain;
  } wch_cfg_t;

  typedef struct packed {
    logic [FLAT_W-1:0]   flat;
    logic                oor;
    logic [WEIGHT_W-1:0] weight;
  } map_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP1,
    ST_MAP2,
    ST_MAP3,
    ST_READ,
    ST_WRITE
  } wch_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wch_bin_map.sv -----
// ----------------------------------------------------------------------------
// wch_bin_map
// Three-stage datapath from a held pixel request to flat bin, range flag and
// weight. Stages load every cycle; the sequencer waits for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wch_bin_map (
  input  wire logic              clk,
  input  wire wch_pkg::wch_cfg_t cfg,
  input  wire logic [1:0]        opcode,
  input  wire logic [7:0]        chan_a,
  input  wire logic [7:0]        chan_b,
  input  wire logic [7:0]        chan_c,
  input  wire logic [11:0]       column,
  input  wire logic [11:0]       bin_address,
  output wch_pkg::map_res_t      res
);

  logic [16:0] prod_a;
  logic [16:0] prod_b;
  logic [16:0] prod_c;
  logic [11:0] col_sat;
  logic [2:0]  factor;

  logic [8:0]  x1_r;
  logic [8:0]  y1_r;
  logic [8:0]  z1_r;
  logic [14:0] cf1_r;
  logic [17:0] bxy1_r;

  logic [8:0]  x2_r;
  logic [17:0] yx2_r;
  logic [26:0] zxy2_r;
  logic [wch_pkg::WEIGHT_W-1:0] w2_r;

  logic [wch_pkg::FLAT_W-1:0] flat;
  wch_pkg::map_res_t          res_r;

  // stage 1: per-channel bins, column clamp and weight factor
  always_comb begin
    prod_a = {9'd0, chan_a} * {8'd0, cfg.bins_x};
    prod_b = {9'd0, chan_b} * {8'd0, cfg.bins_y};
    prod_c = {9'd0, chan_c} * {8'd0, cfg.bins_z};
    if ({{(wch_pkg::COLCMP_W-12){1'b0}}, column} >=
        wch_pkg::COLCMP_W'(wch_pkg::ROW_WIDTH)) begin
      col_sat = 12'(wch_pkg::ROW_WIDTH - 1);
    end else begin
      col_sat = column;
    end
    unique case (cfg.hist_ch)
      wch_pkg::DIM_TWO, wch_pkg::DIM_THREE: factor = cfg.src_ch;
      default:                              factor = 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    x1_r   <= prod_a[16:8];
    y1_r   <= prod_b[16:8];
    z1_r   <= prod_c[16:8];
    cf1_r  <= 15'(col_sat) * 15'(factor);
    bxy1_r <= 18'(cfg.bins_x) * 18'(cfg.bins_y);
  end

  // stage 2: flat bin terms and weight
  always_ff @(posedge clk) begin
    x2_r   <= x1_r;
    yx2_r  <= 18'(y1_r) * 18'(cfg.bins_x);
    zxy2_r <= 27'(z1_r) * 27'(bxy1_r);
    w2_r   <= wch_pkg::WEIGHT_W'(cf1_r) * wch_pkg::WEIGHT_W'(cfg.gain);
  end

  // stage 3: flat bin sum by mode, or the read address, and range check
  always_comb begin
    if (opcode == wch_pkg::OP_ACC) begin
      unique case (cfg.hist_ch)
        wch_pkg::DIM_TWO:
          flat = wch_pkg::FLAT_W'(x2_r) + wch_pkg::FLAT_W'(yx2_r);
        wch_pkg::DIM_THREE:
          flat = wch_pkg::FLAT_W'(x2_r) + wch_pkg::FLAT_W'(yx2_r) +
                 wch_pkg::FLAT_W'(zxy2_r);
        default:
          flat = wch_pkg::FLAT_W'(x2_r);
      endcase
    end else begin
      flat = wch_pkg::FLAT_W'(bin_address);
    end
  end

  always_ff @(posedge clk) begin
    res_r.flat   <= flat;
    res_r.oor    <= (flat >= wch_pkg::FLAT_W'(wch_pkg::HIST_BINS));
    res_r.weight <= w2_r;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_color_histogram_accumulator.sv -----
// ----------------------------------------------------------------------------
// weighted_color_histogram_accumulator
// Weighted 1/2/3-D color histogram in one synchronous memory, with read and
// read-and-clear of single bins.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in_     | in_valid/in_stall  | opcode, chan_a/b/c, column, bin_address
//  out_    | out_valid/out_stall| bin_value, bin_index, out_of_range
//  cfg_    | cfg_valid/cfg_ready| cfg_index (register), cfg_data
//
//  one request at a time: the result is presented after the 3 bin map stages,
//  the memory read, modify and write back, and the next request is taken in
//  the idle state that follows, since the sequencer holds each request through
//  the bin map and read-modify-write.
//  after reset a clearing pass zeroes all HIST_BINS (4096) bins of the store,
//  with in_stall high; configuration writes are taken throughout.
//  a held result waits in the output register; the write back waits with it.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_color_histogram_accumulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_chan_a,
  input  wire logic [7:0]  in_chan_b,
  input  wire logic [7:0]  in_chan_c,
  input  wire logic [11:0] in_column,
  input  wire logic [11:0] in_bin_address,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_bin_value,
  output logic [11:0]      out_bin_index,
  output logic             out_out_of_range,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = wch_pkg::ADDR_W;
  localparam int VW = wch_pkg::VALUE_W;

  wch_pkg::wch_cfg_t   cfg_r;
  wch_pkg::wch_state_t st_r, st_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;

  logic [1:0]  op_r;
  logic [7:0]  a_r, b_r, c_r;
  logic [11:0] col_r, baddr_r;

  wch_pkg::map_res_t map_res;

  logic [VW-1:0] mem [wch_pkg::HIST_BINS];
  logic [VW-1:0] rd_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [VW-1:0] mem_wdata;

  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] out_value_r, out_value_nxt;
  logic [11:0]   out_index_r, out_index_nxt;
  logic          out_oor_r, out_oor_nxt;

  logic          accept;
  logic          can_out;
  logic [VW:0]   sum;
  logic [VW-1:0] sum_sat;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hist_ch <= 2'd1;
      cfg_r.bins_x  <= 9'd256;
      cfg_r.bins_y  <= 9'd1;
      cfg_r.bins_z  <= 9'd1;
      cfg_r.src_ch  <= 3'd1;
      cfg_r.gain    <= 32'd16777216;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wch_pkg::CFG_HIST_CH: cfg_r.hist_ch <= cfg_data[1:0];
        wch_pkg::CFG_BINS_X:  cfg_r.bins_x  <= cfg_data[8:0];
        wch_pkg::CFG_BINS_Y:  cfg_r.bins_y  <= cfg_data[8:0];
        wch_pkg::CFG_BINS_Z:  cfg_r.bins_z  <= cfg_data[8:0];
        wch_pkg::CFG_SRC_CH:  cfg_r.src_ch  <= cfg_data[2:0];
        wch_pkg::CFG_GAIN:    cfg_r.gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  assign in_stall = (st_r != wch_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      a_r     <= in_chan_a;
      b_r     <= in_chan_b;
      c_r     <= in_chan_c;
      col_r   <= in_column;
      baddr_r <= in_bin_address;
    end
  end

  // bin number and weight
  wch_bin_map u_map (
    .clk         (clk),
    .cfg         (cfg_r),
    .opcode      (op_r),
    .chan_a      (a_r),
    .chan_b      (b_r),
    .chan_c      (c_r),
    .column      (col_r),
    .bin_address (baddr_r),
    .res         (map_res)
  );

  // saturating add of the weight to the bin read
  always_comb begin
    sum = {1'b0, rd_r} + (VW + 1)'(map_res.weight);
    if (sum[VW]) begin
      sum_sat = {VW{1'b1}};
    end else begin
      sum_sat = sum[VW-1:0];
    end
  end

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = map_res.flat[AW-1:0];
    mem_wdata     = '0;
    can_out       = !out_valid_r || !out_stall;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_oor_nxt   = out_oor_r;

    unique case (st_r)
      wch_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == AW'(wch_pkg::HIST_BINS - 1)) begin
          st_nxt = wch_pkg::ST_IDLE;
        end
      end
      wch_pkg::ST_IDLE: begin
        if (accept) begin
          st_nxt = wch_pkg::ST_MAP1;
        end
      end
      wch_pkg::ST_MAP1: st_nxt = wch_pkg::ST_MAP2;
      wch_pkg::ST_MAP2: st_nxt = wch_pkg::ST_MAP3;
      wch_pkg::ST_MAP3: st_nxt = wch_pkg::ST_READ;
      wch_pkg::ST_READ: begin
        mem_re = 1'b1;
        st_nxt = wch_pkg::ST_WRITE;
      end
      wch_pkg::ST_WRITE: begin
        if (can_out) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = map_res.flat[11:0];
          out_oor_nxt   = map_res.oor;
          st_nxt        = wch_pkg::ST_IDLE;
          if (map_res.oor) begin
            out_value_nxt = '0;
          end else if (op_r == wch_pkg::OP_ACC) begin
            out_value_nxt = sum_sat;
            mem_we        = 1'b1;
            mem_wdata     = sum_sat;
          end else begin
            out_value_nxt = rd_r;
            mem_we        = (op_r == wch_pkg::OP_CLEAR);
          end
        end
      end
      default: st_nxt = wch_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= wch_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  // histogram store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bin_value    = out_value_r;
  assign out_bin_index    = out_index_r;
  assign out_out_of_range = out_oor_r;

endmodule

`default_nettype wire

// ----- tb/tb_weighted_color_histogram_accumulator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weighted_color_histogram_accumulator
// Self-checking bench for the weighted color histogram. A scoreboard keeps its
// own copy of the bin store and configuration, predicts every result from the
// accepted requests and compares the results in order. Directed requests cover
// the field extremes, every opcode, saturation and out-of-range bins. Random
// phases under varied settings follow, with random idling on both sides, one
// long result hold-off and one drain pause.
// ----------------------------------------------------------------------------

module tb_weighted_color_histogram_accumulator;

  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_ITEMS    = 160;
  localparam int          LONG_HOLD      = 300;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [1:0]  OP_SPARE       = 2'd3;
  localparam logic [63:0] VALUE_MAX      = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  chan_a;
    logic [7:0]  chan_b;
    logic [7:0]  chan_c;
    logic [11:0] column;
    logic [11:0] bin_address;
  } pixel_req_t;

  typedef struct packed {
    logic [47:0] value;
    logic [11:0] index;
    logic        oor;
  } bin_result_t;

  // shadow of the bin store and registers, with the queue of bins still owed
  class histogram_scoreboard;
    logic [47:0] bin_store [wch_pkg::HIST_BINS];
    logic [1:0]  hist_ch;
    logic [8:0]  bins_x;
    logic [8:0]  bins_y;
    logic [8:0]  bins_z;
    logic [2:0]  src_ch;
    logic [31:0] gain;
    bin_result_t expected_bins [$];
    int unsigned mismatches;

    function new();
      foreach (bin_store[i]) bin_store[i] = '0;
      hist_ch     = 2'd1;
      bins_x      = 9'd256;
      bins_y      = 9'd1;
      bins_z      = 9'd1;
      src_ch      = 3'd1;
      gain        = 32'h0100_0000;
      mismatches  = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        wch_pkg::CFG_HIST_CH: hist_ch = data[1:0];
        wch_pkg::CFG_BINS_X:  bins_x  = data[8:0];
        wch_pkg::CFG_BINS_Y:  bins_y  = data[8:0];
        wch_pkg::CFG_BINS_Z:  bins_z  = data[8:0];
        wch_pkg::CFG_SRC_CH:  src_ch  = data[2:0];
        wch_pkg::CFG_GAIN:    gain    = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction

    // work out the bin touched by an accepted request and what it returns
    function void note_request(pixel_req_t req);
      logic [63:0] x, y, z, flat, factor, col, weight, total, addr;
      bin_result_t want;
      if (req.opcode == wch_pkg::OP_ACC) begin
        x   = (64'(req.chan_a) * 64'(bins_x)) >> 8;
        y   = (64'(req.chan_b) * 64'(bins_y)) >> 8;
        z   = (64'(req.chan_c) * 64'(bins_z)) >> 8;
        col = 64'(req.column);
        if (col >= 64'(wch_pkg::ROW_WIDTH)) col = 64'(wch_pkg::ROW_WIDTH - 1);
        case (hist_ch)
          wch_pkg::DIM_TWO: begin
            flat   = x + y * 64'(bins_x);
            factor = 64'(src_ch);
          end
          wch_pkg::DIM_THREE: begin
            flat   = x + y * 64'(bins_x) + z * 64'(bins_x) * 64'(bins_y);
            factor = 64'(src_ch);
          end
          default: begin
            flat   = x;
            factor = 64'd1;
          end
        endcase
        if (flat >= 64'(wch_pkg::HIST_BINS)) begin
          want = '{value: '0, index: flat[11:0], oor: 1'b1};
        end else begin
          weight = col * factor * 64'(gain);
          total  = 64'(bin_store[flat[11:0]]) + weight;
          if (total > VALUE_MAX) total = VALUE_MAX;
          bin_store[flat[11:0]] = total[47:0];
          want = '{value: total[47:0], index: flat[11:0], oor: 1'b0};
        end
      end else begin
        // read, read-and-clear, and the spare opcode acting as a read
        addr = 64'(req.bin_address);
        if (addr >= 64'(wch_pkg::HIST_BINS)) begin
          want = '{value: '0, index: addr[11:0], oor: 1'b1};
        end else begin
          want = '{value: bin_store[addr[11:0]], index: addr[11:0], oor: 1'b0};
          if (req.opcode == wch_pkg::OP_CLEAR) bin_store[addr[11:0]] = '0;
        end
      end
      expected_bins.push_back(want);
    endfunction

    function void check_bin_result(bin_result_t got);
      bin_result_t want;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %h index %0d oor %b",
                   got.value, got.index, got.oor);
        return;
      end
      want = expected_bins.pop_front();
      if (got.value !== want.value || got.index !== want.index || got.oor !== want.oor) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected value %h index %0d oor %b, got value %h index %0d oor %b",
                   want.value, want.index, want.oor, got.value, got.index, got.oor);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [7:0]  in_chan_a;
  logic [7:0]  in_chan_b;
  logic [7:0]  in_chan_c;
  logic [11:0] in_column;
  logic [11:0] in_bin_address;
  logic        out_valid;
  logic        out_stall;
  logic [47:0] out_bin_value;
  logic [11:0] out_bin_index;
  logic        out_out_of_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  histogram_scoreboard board;
  bit          idle_on;
  bit          hold_request;
  logic [23:0] palette [4];
  logic [11:0] recent_bins [$];
  int unsigned quiet_cycles;

  weighted_color_histogram_accumulator dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stall bursts and the one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_bin_result({out_bin_value, out_bin_index, out_out_of_range});
      if (!out_out_of_range) begin
        recent_bins.push_back(out_bin_index);
        if (recent_bins.size() > 16) void'(recent_bins.pop_front());
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pixel_req_t make_request(logic [1:0] op, logic [7:0] a, logic [7:0] b,
                                              logic [7:0] c, logic [11:0] col,
                                              logic [11:0] addr);
    return '{opcode: op, chan_a: a, chan_b: b, chan_c: c, column: col, bin_address: addr};
  endfunction

  function automatic logic [8:0] random_bins();
    if ($urandom_range(0, 3) == 0) return 9'($urandom);
    return 9'($urandom_range(1, 20));
  endfunction

  function automatic wch_pkg::wch_cfg_t random_settings();
    wch_pkg::wch_cfg_t s;
    s.hist_ch = 2'($urandom);
    s.bins_x  = random_bins();
    s.bins_y  = random_bins();
    s.bins_z  = random_bins();
    s.src_ch  = 3'($urandom);
    s.gain    = $urandom;
    return s;
  endfunction

  // mostly accumulates; colors often from a small palette so bins get hit again
  function automatic pixel_req_t random_request();
    pixel_req_t  req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      req.opcode = wch_pkg::OP_ACC;
    else if (pick < 82) req.opcode = wch_pkg::OP_READ;
    else if (pick < 94) req.opcode = wch_pkg::OP_CLEAR;
    else                req.opcode = OP_SPARE;
    if ($urandom_range(0, 1) == 1)
      {req.chan_a, req.chan_b, req.chan_c} = palette[$urandom_range(0, 3)];
    else
      {req.chan_a, req.chan_b, req.chan_c} = 24'($urandom);
    case ($urandom_range(0, 7))
      0:       req.column = '0;
      1:       req.column = '1;
      default: req.column = 12'($urandom);
    endcase
    if (recent_bins.size() != 0 && $urandom_range(0, 2) != 0)
      req.bin_address = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
    else
      req.bin_address = 12'($urandom);
    return req;
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
  endtask

  // valid stays high across the six writes and drops after the last
  task automatic apply_settings(input wch_pkg::wch_cfg_t s);
    write_register(wch_pkg::CFG_HIST_CH, 32'(s.hist_ch));
    write_register(wch_pkg::CFG_BINS_X,  32'(s.bins_x));
    write_register(wch_pkg::CFG_BINS_Y,  32'(s.bins_y));
    write_register(wch_pkg::CFG_BINS_Z,  32'(s.bins_z));
    write_register(wch_pkg::CFG_SRC_CH,  32'(s.src_ch));
    write_register(wch_pkg::CFG_GAIN,    s.gain);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input pixel_req_t req);
    in_opcode      <= req.opcode;
    in_chan_a      <= req.chan_a;
    in_chan_b      <= req.chan_b;
    in_chan_c      <= req.chan_c;
    in_column      <= req.column;
    in_bin_address <= req.bin_address;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_request(req);
    // optional gap before the next request
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    wch_pkg::wch_cfg_t plan [NUM_PHASES];
    int       phase;
    int       k;

    board          = new();
    idle_on        = 1'b1;
    hold_request   = 1'b0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = wch_pkg::OP_ACC;
    in_chan_a      = '0;
    in_chan_b      = '0;
    in_chan_c      = '0;
    in_column      = '0;
    in_bin_address = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = wch_pkg::CFG_HIST_CH;
    cfg_data       = '0;

    plan[0] = '{hist_ch: 2'd1, bins_x: 9'd256, bins_y: 9'd1, bins_z: 9'd1,
                src_ch: 3'd1, gain: 32'h0100_0000};
    plan[1] = '{hist_ch: wch_pkg::DIM_TWO, bins_x: 9'd16, bins_y: 9'd16, bins_z: 9'd1,
                src_ch: 3'd4, gain: 32'h0010_0000};
    // exactly fills the store
    plan[2] = '{hist_ch: wch_pkg::DIM_THREE, bins_x: 9'd16, bins_y: 9'd16, bins_z: 9'd16,
                src_ch: 3'd3, gain: 32'h0100_0000};
    // widest bin counts, largest factor and gain
    plan[3] = '{hist_ch: wch_pkg::DIM_THREE, bins_x: 9'd511, bins_y: 9'd511,
                bins_z: 9'd511, src_ch: 3'd7, gain: 32'hFFFF_FFFF};
    // zero bins along x and zero factor, all hits land on bin 0 with no weight
    plan[4] = '{hist_ch: wch_pkg::DIM_TWO, bins_x: 9'd0, bins_y: 9'd300, bins_z: 9'd5,
                src_ch: 3'd0, gain: 32'd0};
    // dimensionality zero acts as one channel
    plan[5] = '{hist_ch: 2'd0, bins_x: 9'd64, bins_y: 9'd0, bins_z: 9'd0,
                src_ch: 3'd6, gain: $urandom};
    plan[6] = random_settings();
    plan[7] = random_settings();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_on = (phase != NUM_PHASES - 1);
      apply_settings(plan[phase]);
      foreach (palette[i]) palette[i] = 24'($urandom);

      if (phase == 0) begin
        // one-channel directed: extremes, repeat hits, every opcode
        send_request(make_request(wch_pkg::OP_ACC,   8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF));
        send_request(make_request(wch_pkg::OP_ACC,   8'hFF, 8'h00, 8'h00, 12'hFFF, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'h80, 8'hAA, 8'h55, 12'h001, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'h01, 8'h00, 8'h00, 12'h800, 12'h000));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'h0FF));
        send_request(make_request(wch_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 12'h000, 12'h0FF));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'h0FF));
        send_request(make_request(OP_SPARE,          8'h00, 8'h00, 8'h00, 12'h000, 12'h080));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'hFFF));
        send_request(make_request(wch_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'h55, 8'h00, 8'h00, 12'hAAA, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'hAA, 8'h00, 8'h00, 12'h555, 12'h000));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'hAAA));
        send_request(make_request(wch_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 12'h000, 12'h555));
      end else if (phase == 3) begin
        // saturation of bin 0, then one bin beyond the store and one within it
        repeat (4)
          send_request(make_request(wch_pkg::OP_ACC, 8'h00, 8'h00, 8'h00, 12'hFFF, 12'h000));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_CLEAR, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_READ,  8'h00, 8'h00, 8'h00, 12'h000, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'h000));
        send_request(make_request(wch_pkg::OP_ACC,   8'h01, 8'h01, 8'h00, 12'h123, 12'h000));
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 1 && k == PHASE_ITEMS / 2) hold_request = 1'b1;
        if (phase == 2 && k == PHASE_ITEMS / 2) wait_for_results();
        send_request(random_request());
      end
      wait_for_results();
    end

    if (board.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/wch_pkg.sv
hw/rtl/wch_bin_map.sv
hw/rtl/weighted_color_histogram_accumulator.sv
tb/tb_weighted_color_histogram_accumulator.sv
